/* hw/rtl/spmc_gap_ring_queue_macros.svh */
// assertion macros for the gap ring queue
`ifndef SPMC_GAP_RING_QUEUE_MACROS_SVH
`define SPMC_GAP_RING_QUEUE_MACROS_SVH

// property that holds outside reset
`define SGRQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked during reset too
`define SGRQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/sgrq_pkg.sv */
// ----------------------------------------------------------------------------
// sgrq_pkg
// types and constants shared by the gap ring queue modules
// ----------------------------------------------------------------------------
`default_nettype none
package sgrq_pkg;
    localparam int DEPTH = 64;
    localparam int CONSUMERS = 8;
    localparam int PAYLOAD_BITS = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = 31;
    localparam int SIZE_W = 7;
    localparam int WHO_W = 3;
    localparam logic [31:0] FREE_MARK = 32'hFFFF_FFFF;
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

    typedef enum logic [2:0] {
        ST_STORED    = 3'd0,
        ST_SKIPPED   = 3'd1,
        ST_DEQUEUED  = 3'd2,
        ST_GAP       = 3'd3,
        ST_NOT_READY = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_DIV,
        S_READ,
        S_UPDATE,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic load;
        logic div_start;
        logic read;
        logic update;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic div_done;
        logic bypass;
    } t_stat;
endpackage
`default_nettype wire

/* hw/rtl/sgrq_div.sv */
// ----------------------------------------------------------------------------
// sgrq_div
// restoring divider, one quotient bit per cycle, remainder only
// ----------------------------------------------------------------------------
`default_nettype none
module sgrq_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [sgrq_pkg::CNT_W-1:0]     i_dividend,
    input  wire logic [sgrq_pkg::SIZE_W-1:0]    i_divisor,
    output logic                                o_done,
    output logic [sgrq_pkg::IDX_W-1:0]          o_rem
);
    localparam int CW = $clog2(sgrq_pkg::CNT_W + 1);

    logic [sgrq_pkg::CNT_W-1:0]  r_dvd;
    logic [sgrq_pkg::SIZE_W:0]   r_rem;
    logic [sgrq_pkg::SIZE_W-1:0] r_dvs;
    logic [CW-1:0]               r_cnt;
    logic                        r_busy;
    logic [sgrq_pkg::SIZE_W:0]   shifted;
    logic [sgrq_pkg::SIZE_W:0]   n_rem;

    // one shift-subtract step
    always_comb begin
        shifted = {r_rem[sgrq_pkg::SIZE_W-1:0], r_dvd[sgrq_pkg::CNT_W-1]};
        if (shifted >= {1'b0, r_dvs}) begin
            n_rem = shifted - {1'b0, r_dvs};
        end else begin
            n_rem = shifted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(sgrq_pkg::CNT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[sgrq_pkg::CNT_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_rem = r_rem[sgrq_pkg::IDX_W-1:0];
endmodule
`default_nettype wire

/* hw/rtl/sgrq_datapath.sv */
// ----------------------------------------------------------------------------
// sgrq_datapath
// cell memories, counters, consumer ranks, divider and result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "spmc_gap_ring_queue_macros.svh"
module sgrq_datapath (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire sgrq_pkg::t_cmd                      i_cmd,
    output sgrq_pkg::t_stat                          o_stat,
    input  wire logic [sgrq_pkg::SIZE_W-1:0]         i_ring_size,
    input  wire logic                                i_operation,
    input  wire logic [sgrq_pkg::WHO_W-1:0]          i_consumer,
    input  wire logic [sgrq_pkg::PAYLOAD_BITS-1:0]   i_payload_in,
    output logic [2:0]                               o_status,
    output logic [5:0]                               o_cell_index,
    output logic [sgrq_pkg::CNT_W-1:0]               o_sequence_res,
    output logic [sgrq_pkg::PAYLOAD_BITS-1:0]        o_payload_out,
    output logic [sgrq_pkg::CNT_W-1:0]               o_dequeued_total
);
    localparam int IW = sgrq_pkg::IDX_W;
    localparam int CW = sgrq_pkg::CNT_W;
    localparam int PB = sgrq_pkg::PAYLOAD_BITS;
    localparam int NC = sgrq_pkg::CONSUMERS;
    localparam int WW = (NC > 1) ? $clog2(NC) : 1;

    // cell memories
    logic [31:0] r_tag_mem [sgrq_pkg::DEPTH];
    logic [31:0] r_gap_mem [sgrq_pkg::DEPTH];
    logic [PB-1:0] r_data_mem [sgrq_pkg::DEPTH];
    logic [31:0] r_tag_q;
    logic [31:0] r_gap_q;
    logic [PB-1:0] r_data_q;

    logic [IW:0]   r_clr;
    logic [CW-1:0] r_tail;
    logic [CW-1:0] r_head;
    logic [CW-1:0] r_done;
    logic [CW-1:0] r_rank [NC];
    logic [NC-1:0] r_pend;

    logic          r_op;
    logic [WW-1:0] r_who;
    logic          r_bad;
    logic [PB-1:0] r_pay;
    logic [CW-1:0] r_seq;
    logic [IW-1:0] r_idx;

    logic [sgrq_pkg::SIZE_W-1:0] eff_size;
    logic                        div_done;
    logic [IW-1:0]               div_rem;
    logic                        bad_who;
    logic [WW-1:0]               who_idx;

    // clamp ring size into 1..DEPTH
    always_comb begin
        if (i_ring_size == '0) begin
            eff_size = sgrq_pkg::SIZE_W'(1);
        end else if (32'(i_ring_size) > 32'(sgrq_pkg::DEPTH)) begin
            eff_size = sgrq_pkg::SIZE_W'(sgrq_pkg::DEPTH);
        end else begin
            eff_size = i_ring_size;
        end
    end

    assign bad_who = 32'(i_consumer) >= 32'(NC);
    assign who_idx = WW'(i_consumer);

    sgrq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_seq),
        .i_divisor  (eff_size),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // control-side state: counters, pending bits, clear sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_tail <= '0;
            r_head <= '0;
            r_done <= '0;
            r_pend <= '0;
        end else begin
            if (i_cmd.clear_step) begin
                r_clr <= r_clr + 1'b1;
            end
            // claim the first rank on load
            if (i_cmd.load && i_operation && !bad_who && !r_pend[who_idx]) begin
                r_head <= r_head + 1'b1;
                r_pend[who_idx] <= 1'b1;
            end
            if (i_cmd.update) begin
                if (!r_op) begin
                    r_tail <= r_tail + 1'b1;
                end else if (r_tag_q == {1'b0, r_seq}) begin
                    r_done <= r_done + 1'b1;
                    r_pend[r_who] <= 1'b0;
                end else if (!r_gap_q[31] && r_gap_q[CW-1:0] >= r_seq) begin
                    r_head <= r_head + 1'b1;
                end
            end
        end
    end

    // ranks need no reset, pending bit guards them
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_operation && !bad_who && !r_pend[who_idx]) begin
            r_rank[who_idx] <= r_head;
        end
        if (i_cmd.update && r_op && r_tag_q != {1'b0, r_seq}
            && !r_gap_q[31] && r_gap_q[CW-1:0] >= r_seq) begin
            r_rank[r_who] <= r_head;
        end
    end

    // latch the attempt
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_who <= who_idx;
            r_bad <= i_operation && bad_who;
            r_pay <= i_payload_in;
            if (!i_operation) begin
                r_seq <= r_tail;
            end else if (bad_who) begin
                r_seq <= '0;
            end else if (r_pend[who_idx]) begin
                r_seq <= r_rank[who_idx];
            end else begin
                r_seq <= r_head;
            end
        end
        if (div_done) begin
            r_idx <= div_rem;
        end
    end

    // cell memory access
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) begin
            r_tag_mem[r_clr[IW-1:0]] <= sgrq_pkg::FREE_MARK;
            r_gap_mem[r_clr[IW-1:0]] <= sgrq_pkg::FREE_MARK;
        end else if (i_cmd.update) begin
            if (!r_op) begin
                if (r_tag_q[31]) begin
                    r_tag_mem[r_idx] <= {1'b0, r_seq};
                end else begin
                    r_gap_mem[r_idx] <= {1'b0, r_seq};
                end
            end else if (r_tag_q == {1'b0, r_seq}) begin
                r_tag_mem[r_idx] <= sgrq_pkg::FREE_MARK;
            end
        end
        if (i_cmd.read) begin
            r_tag_q  <= r_tag_mem[r_idx];
            r_gap_q  <= r_gap_mem[r_idx];
            r_data_q <= r_data_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update && !r_op && r_tag_q[31]) begin
            r_data_mem[r_idx] <= r_pay;
        end
    end

    // result register, loaded after the update
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_dequeued_total <= r_done;
            o_payload_out    <= '0;
            if (r_bad) begin
                o_status       <= sgrq_pkg::ST_NOT_READY;
                o_cell_index   <= '0;
                o_sequence_res <= '0;
            end else begin
                o_cell_index   <= 6'(r_idx);
                o_sequence_res <= r_seq;
                if (!r_op) begin
                    o_status <= r_tag_q[31] ? sgrq_pkg::ST_STORED : sgrq_pkg::ST_SKIPPED;
                end else if (r_tag_q == {1'b0, r_seq}) begin
                    o_status      <= sgrq_pkg::ST_DEQUEUED;
                    o_payload_out <= r_data_q;
                end else if (!r_gap_q[31] && r_gap_q[CW-1:0] >= r_seq) begin
                    o_status <= sgrq_pkg::ST_GAP;
                end else begin
                    o_status <= sgrq_pkg::ST_NOT_READY;
                end
            end
        end
    end

    assign o_stat.clear_done = r_clr[IW];
    assign o_stat.div_done   = div_done;
    assign o_stat.bypass     = r_bad;

    `SGRQ_ASSERT(a_clear_idle, i_clk, i_rst_n,
        i_cmd.clear_step |-> !(i_cmd.update || i_cmd.load),
        "clear sweep overlaps an item")
    `SGRQ_ASSERT(a_head_step, i_clk, i_rst_n,
        (i_cmd.update && !r_op) |=> (r_tail == $past(r_tail) + 1'b1),
        "tail did not advance on enqueue")
    `SGRQ_ASSERT(a_idx_range, i_clk, i_rst_n,
        i_cmd.read |-> (32'(r_idx) < 32'(eff_size)),
        "cell index beyond ring size")
endmodule
`default_nettype wire

/* hw/rtl/sgrq_ctrl.sv */
// ----------------------------------------------------------------------------
// sgrq_ctrl
// sequencer: clear sweep, divide, cell read, update, result handoff
// ----------------------------------------------------------------------------
`default_nettype none
`include "spmc_gap_ring_queue_macros.svh"
module sgrq_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    output logic                 o_valid,
    input  wire logic            i_stall,
    input  wire sgrq_pkg::t_stat i_stat,
    output sgrq_pkg::t_cmd       o_cmd
);
    sgrq_pkg::t_state r_state, n_state;
    logic             r_ovalid;
    logic             r_kick;
    logic             accept;

    assign accept = i_valid && !o_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sgrq_pkg::S_CLEAR:  if (i_stat.clear_done) n_state = sgrq_pkg::S_IDLE;
            sgrq_pkg::S_IDLE:   if (accept) n_state = sgrq_pkg::S_DIV;
            sgrq_pkg::S_DIV: begin
                if (i_stat.div_done) n_state = sgrq_pkg::S_READ;
            end
            sgrq_pkg::S_READ:   n_state = sgrq_pkg::S_UPDATE;
            sgrq_pkg::S_UPDATE: n_state = sgrq_pkg::S_OUT;
            sgrq_pkg::S_OUT:    if (!r_ovalid || !i_stall) n_state = sgrq_pkg::S_IDLE;
            default:            n_state = sgrq_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        o_stall = 1'b1;
        unique case (r_state)
            sgrq_pkg::S_CLEAR:  o_cmd.clear_step = !i_stat.clear_done;
            sgrq_pkg::S_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
            end
            // start pulse on the first divide cycle, seq is latched by then
            sgrq_pkg::S_DIV:    o_cmd.div_start = r_kick;
            sgrq_pkg::S_READ:   o_cmd.read = 1'b1;
            sgrq_pkg::S_UPDATE: o_cmd.update = !i_stat.bypass;
            sgrq_pkg::S_OUT:    o_cmd.out_load = !r_ovalid || !i_stall;
            default:            o_cmd = '0;
        endcase
    end

    // state, start pulse and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sgrq_pkg::S_CLEAR;
            r_ovalid <= 1'b0;
            r_kick   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kick  <= accept;
            if (o_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid = r_ovalid;

    `SGRQ_ASSERT(a_one_load, i_clk, i_rst_n,
        o_cmd.load |-> (r_state == sgrq_pkg::S_IDLE),
        "load outside idle")
    `SGRQ_ASSERT(a_out_hold, i_clk, i_rst_n,
        (r_ovalid && i_stall) |=> r_ovalid,
        "result dropped while stalled")
    `SGRQ_ASSERT(a_no_accept_busy, i_clk, i_rst_n,
        (r_state != sgrq_pkg::S_IDLE) |-> o_stall,
        "input taken while busy")
endmodule
`default_nettype wire

/* hw/rtl/spmc_gap_ring_queue.sv */
// ----------------------------------------------------------------------------
// spmc_gap_ring_queue
// single-producer multi-consumer ring queue with gap marking
// ----------------------------------------------------------------------------
// channel | direction | handshake         | payload
// in      | input     | i_valid / o_stall | operation, consumer, payload_in
// out     | output    | o_valid / i_stall | status, cell_index, sequence_res,
//         |           |                   | payload_out, dequeued_total
// cfg     | input     | apb write         | ring_size at address 0
//
// the result of an item is loaded after it is accepted, in these steps: divider
// start, 31 steps of the remainder divider, index latch, cell read, update,
// result load. the next item is accepted only after that result is loaded.
// after reset a clearing pass sweeps the tag and gap memories.
// a stalled result holds in the output register; the next result waits for it.
// ----------------------------------------------------------------------------
`default_nettype none
module spmc_gap_ring_queue (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic                                i_operation,
    input  wire logic [2:0]                          i_consumer,
    input  wire logic [sgrq_pkg::PAYLOAD_BITS-1:0]   i_payload_in,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [2:0]                               o_status,
    output logic [5:0]                               o_cell_index,
    output logic [30:0]                              o_sequence_res,
    output logic [sgrq_pkg::PAYLOAD_BITS-1:0]        o_payload_out,
    output logic [30:0]                              o_dequeued_total,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [1:0]                          paddr,
    input  wire logic [31:0]                         pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready
);
    sgrq_pkg::t_cmd  cmd;
    sgrq_pkg::t_stat stat;
    logic [sgrq_pkg::SIZE_W-1:0] r_ring_size;

    // register file
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_size <= sgrq_pkg::SIZE_RESET;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            r_ring_size <= pwdata[sgrq_pkg::SIZE_W-1:0];
        end
    end
    assign prdata = (paddr == 2'd0) ? 32'(r_ring_size) : '0;

    sgrq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    sgrq_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_ring_size      (r_ring_size),
        .i_operation      (i_operation),
        .i_consumer       (i_consumer),
        .i_payload_in     (i_payload_in),
        .o_status         (o_status),
        .o_cell_index     (o_cell_index),
        .o_sequence_res   (o_sequence_res),
        .o_payload_out    (o_payload_out),
        .o_dequeued_total (o_dequeued_total)
    );
endmodule
`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// testbench for the gap ring queue. It drives directed and random enqueue and
// dequeue attempts with random gaps on the input and random stalls on the
// output. It changes the ring size over the apb port between phases. Each
// result is checked against a predictor of the ring held here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 50;
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;
    localparam logic [1:0] ADDR_RING_SIZE = 2'd0;

    typedef struct packed {
        sgrq_pkg::t_status status;
        logic [5:0]  cell_index;
        logic [30:0] sequence_res;
        logic [63:0] payload_out;
        logic [30:0] dequeued_total;
    } t_attempt_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_operation = 1'b0;
    logic [2:0] i_consumer = '0;
    logic [sgrq_pkg::PAYLOAD_BITS-1:0] i_payload_in = '0;
    logic i_stall = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    wire logic o_stall, o_valid, pready;
    wire logic [2:0] o_status;
    wire logic [5:0] o_cell_index;
    wire logic [30:0] o_sequence_res, o_dequeued_total;
    wire logic [sgrq_pkg::PAYLOAD_BITS-1:0] o_payload_out;
    wire logic [31:0] prdata;

    spmc_gap_ring_queue u_dut (.*);

    // clock, 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ring mirror
    logic [31:0] ring_tag [sgrq_pkg::DEPTH];
    logic [31:0] ring_gap [sgrq_pkg::DEPTH];
    logic [63:0] ring_data [sgrq_pkg::DEPTH];
    logic [30:0] tail_seq, head_seq, deq_count;
    logic [30:0] rank_of [sgrq_pkg::CONSUMERS];
    logic        holds_rank [sgrq_pkg::CONSUMERS];
    logic [6:0]  ring_size_reg;

    t_attempt_res pending_res [$];
    int fail_count = 0;
    int quiet_cycles = 0;

    // receiver stall control
    int stall_pct = 0;
    int hold_cycles = 0;
    // sender burst control
    int burst_left = 0;
    int max_gap = 4;

    function automatic logic [30:0] claim_head();
        logic [30:0] r;
        r = head_seq;
        head_seq = head_seq + 31'd1;
        return r;
    endfunction

    function automatic void predict_attempt(logic op, logic [2:0] who,
                                            logic [63:0] pay);
        int unsigned size;
        int unsigned idx;
        logic [30:0] seq;
        t_attempt_res r;
        size = ring_size_reg;
        if (size == 0) size = 1;
        if (size > sgrq_pkg::DEPTH) size = sgrq_pkg::DEPTH;
        r = '0;
        if (op == OP_ENQ) begin
            seq = tail_seq;
            idx = seq % size;
            if (ring_tag[idx][31]) begin
                ring_data[idx] = pay;
                ring_tag[idx] = {1'b0, seq};
                r.status = sgrq_pkg::ST_STORED;
            end else begin
                ring_gap[idx] = {1'b0, seq};
                r.status = sgrq_pkg::ST_SKIPPED;
            end
            tail_seq = seq + 31'd1;
        end else begin
            if (!holds_rank[who]) begin
                rank_of[who] = claim_head();
                holds_rank[who] = 1'b1;
            end
            seq = rank_of[who];
            idx = seq % size;
            if (ring_tag[idx] == {1'b0, seq}) begin
                r.payload_out = ring_data[idx];
                ring_tag[idx] = sgrq_pkg::FREE_MARK;
                deq_count = deq_count + 31'd1;
                holds_rank[who] = 1'b0;
                r.status = sgrq_pkg::ST_DEQUEUED;
            end else if (!ring_gap[idx][31] && ring_gap[idx][30:0] >= seq) begin
                rank_of[who] = claim_head();
                r.status = sgrq_pkg::ST_GAP;
            end else begin
                r.status = sgrq_pkg::ST_NOT_READY;
            end
        end
        r.cell_index = idx[5:0];
        r.sequence_res = seq;
        r.dequeued_total = deq_count;
        pending_res.push_back(r);
    endfunction

    // send one item, with burst gaps in front of it
    task automatic send_item(logic op, logic [2:0] who, logic [63:0] pay);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_operation <= op;
        i_consumer <= who;
        i_payload_in <= pay;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_attempt(op, who, pay);
    endtask

    task automatic end_burst();
        i_valid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic wait_drained();
        end_burst();
        @(posedge i_clk);
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_ring_size(logic [31:0] value);
        wait_drained();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_RING_SIZE;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        ring_size_reg = value[6:0];
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // every status from a hand-built sequence, with payload extremes
    task automatic test_directed();
        stall_pct = 0;
        max_gap = 2;
        send_item(OP_DEQ, 3'd0, '0);
        send_item(OP_ENQ, 3'd5, '0);
        send_item(OP_DEQ, 3'd0, '1);
        send_item(OP_ENQ, 3'd0, '1);
        send_item(OP_DEQ, 3'd7, '0);
        write_ring_size(32'd1);
        send_item(OP_ENQ, 3'd0, 64'hA5A5_5A5A_F00F_0FF0);
        send_item(OP_ENQ, 3'd0, 64'h5A5A_A5A5_0FF0_F00F);
        send_item(OP_DEQ, 3'd1, '0);
        send_item(OP_DEQ, 3'd1, '0);
        send_item(OP_DEQ, 3'd2, '0);
        send_item(OP_DEQ, 3'd2, '0);
        send_item(OP_ENQ, 3'd0, '1);
        send_item(OP_DEQ, 3'd2, '0);
        send_item(OP_DEQ, 3'd3, '0);
        wait_drained();
    endtask

    // random attempts at one ring size
    task automatic test_random_phase(logic [31:0] size, int count, int pct);
        int enq_pct;
        write_ring_size(size);
        stall_pct = pct;
        max_gap = $urandom_range(0, 6);
        enq_pct = $urandom_range(40, 65);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < enq_pct)
                send_item(OP_ENQ, 3'($urandom()), rand_word());
            else
                send_item(OP_DEQ, 3'($urandom_range(0, 7)), rand_word());
        end
        wait_drained();
    endtask

    // long receiver hold while the sender keeps offering
    task automatic test_backpressure();
        stall_pct = 0;
        max_gap = 0;
        hold_cycles = 300;
        for (int n = 0; n < 20; n++)
            send_item(n[0] ? OP_DEQ : OP_ENQ, 3'(n % 3), rand_word());
        wait_drained();
    endtask

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_attempt_res exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_res.size() == 0) begin
                $display("%0t: unexpected result status %0d", $realtime, o_status);
                fail_count++;
            end else begin
                exp_r = pending_res.pop_front();
                if (o_status !== exp_r.status) begin
                    $display("%0t: status exp %0d got %0d", $realtime,
                             exp_r.status, o_status);
                    fail_count++;
                end
                if (o_cell_index !== exp_r.cell_index) begin
                    $display("%0t: cell_index exp %0d got %0d", $realtime,
                             exp_r.cell_index, o_cell_index);
                    fail_count++;
                end
                if (o_sequence_res !== exp_r.sequence_res) begin
                    $display("%0t: sequence_res exp %0d got %0d", $realtime,
                             exp_r.sequence_res, o_sequence_res);
                    fail_count++;
                end
                if (o_payload_out !== exp_r.payload_out) begin
                    $display("%0t: payload_out exp %h got %h", $realtime,
                             exp_r.payload_out, o_payload_out);
                    fail_count++;
                end
                if (o_dequeued_total !== exp_r.dequeued_total) begin
                    $display("%0t: dequeued_total exp %0d got %0d", $realtime,
                             exp_r.dequeued_total, o_dequeued_total);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < sgrq_pkg::DEPTH; k++) begin
            ring_tag[k] = sgrq_pkg::FREE_MARK;
            ring_gap[k] = sgrq_pkg::FREE_MARK;
            ring_data[k] = '0;
        end
        for (int k = 0; k < sgrq_pkg::CONSUMERS; k++) begin
            rank_of[k] = '0;
            holds_rank[k] = 1'b0;
        end
        tail_seq = '0;
        head_seq = '0;
        deq_count = '0;
        ring_size_reg = sgrq_pkg::SIZE_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_phase(32'd64, 70, 30);
        test_random_phase(32'd0, 40, 10);
        test_random_phase(32'd127, 60, 50);
        test_backpressure();
        test_random_phase(32'd3, 70, 0);
        test_random_phase(32'd2, 60, 40);
        test_random_phase(32'd17, 60, 20);
        test_random_phase(32'd1, 30, 30);
        wait_drained();

        if (fail_count == 0 && pending_res.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* files.f */
+incdir+hw/rtl
hw/rtl/sgrq_pkg.sv
hw/rtl/sgrq_div.sv
hw/rtl/sgrq_datapath.sv
hw/rtl/sgrq_ctrl.sv
hw/rtl/spmc_gap_ring_queue.sv
tb/tb_top.sv
